### hdl/spimi_pkg.sv
// Package for the SPI master instruction transfer block.
// Holds the item and result types, phase and status codes, and fixed constants.
// No dependencies.
`default_nettype none

package spimi_pkg;

    // Header layout: read flag, two-bit length code, address field
    localparam int HEADER_BITS    = 16;
    localparam int ADDR_FIELD     = 13;
    localparam int ADDR_BITS_DEF  = 13;
    localparam int IN_WIDTH       = 16;
    localparam int CFG_WIDTH      = 13;

    localparam logic [ADDR_FIELD-1:0] MAX_ADDR_RESET = 13'h0509;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_POWER_ON    = 1'b0,
        CFG_MAX_ADDRESS = 1'b1
    } cfg_index_t;

    // Transfer phase
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_DATA    = 3'd2,
        PH_HOLD    = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    // Start request outcome
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2,
        ST_BUSY     = 2'd3
    } start_status_t;

    // One input item
    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  byte_count;
        logic        is_read;
        logic [7:0]  write_byte;
        logic        serial_in;
    } item_t;

    // One result item
    typedef struct packed {
        logic          chip_select_n;
        logic          serial_clock;
        logic          serial_out;
        logic          byte_loaded;
        logic [7:0]    read_byte;
        logic          read_valid;
        logic          done_res;
        start_status_t start_status;
    } result_t;

    // Configuration register contents
    typedef struct packed {
        logic                  power_on;
        logic [ADDR_FIELD-1:0] max_address;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/spi_master_instruction_transfer.sv
// Top level of the SPI master instruction transfer block.
// Holds the configuration registers and ties the input register to the engine.
// Uses spimi_pkg, spimi_in_reg and spimi_engine.
`default_nettype none

// Each input item is one half-bit tick of a mode 0 SPI transfer, optionally
// carrying a start request (tuser high). An accepted start drops select and
// sends a 16-bit header (read flag, length code, address) MSB first, then the
// data bytes, each bit over two ticks: clock low with data set up, then clock
// high. A hold tick and a release tick close the transfer. Every item yields
// exactly one result with the pin levels and status. Items go through an input
// register and a result register with combinational logic between them, so one
// item is taken per clock cycle at full rate and the result of an item is loaded
// when the engine takes it from the input register; the only stall is a result
// not taken on the output side. Configuration writes take effect on the next
// clock edge and are meant to be done while no items are in flight.

module spi_master_instruction_transfer
#(
    parameter int ADDR_BITS = spimi_pkg::ADDR_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // address[15:0], byte_count[23:16], is_read[24], write_byte[32:25],
    // serial_in[33], zero fill [39:34]
    input  wire logic [39:0] s_axis_tdata,
    // action
    input  wire logic [0:0]  s_axis_tuser,
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // chip_select_n[0], serial_clock[1], serial_out[2], byte_loaded[3],
    // read_byte[11:4], read_valid[12], done_res[13], start_status[15:14]
    output logic [15:0]      m_axis_tdata
);

    spimi_pkg::cfg_t    cfg_reg;
    spimi_pkg::item_t   in_item;
    spimi_pkg::item_t   held_item;
    spimi_pkg::result_t res;
    logic               held_valid;
    logic               take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on    <= 1'b0;
            cfg_reg.max_address <= spimi_pkg::MAX_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            case (spimi_pkg::cfg_index_t'(cfg_index))
                spimi_pkg::CFG_POWER_ON:    cfg_reg.power_on    <= cfg_data[0];
                spimi_pkg::CFG_MAX_ADDRESS: cfg_reg.max_address <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Unpack the input item
    always_comb
    begin
        in_item.action     = s_axis_tuser[0];
        in_item.address    = s_axis_tdata[15:0];
        in_item.byte_count = s_axis_tdata[23:16];
        in_item.is_read    = s_axis_tdata[24];
        in_item.write_byte = s_axis_tdata[32:25];
        in_item.serial_in  = s_axis_tdata[33];
    end

    spimi_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (take)
    );

    spimi_engine
    #(
        .ADDR_BITS (ADDR_BITS)
    )
    u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (held_valid),
        .item       (held_item),
        .take       (take),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    // Pack the result item
    assign m_axis_tdata = {res.start_status, res.done_res, res.read_valid, res.read_byte,
                           res.byte_loaded, res.serial_out, res.serial_clock,
                           res.chip_select_n};

    // Input side only stalls while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a pending result");

    // Select high always comes with clock low
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.chip_select_n) |-> !res.serial_clock)
        else $error("clock high while select released");

    // A completed read byte only appears inside a running transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.read_valid) |->
            (!res.chip_select_n && !res.byte_loaded
             && (res.start_status != spimi_pkg::ST_ACCEPTED)))
        else $error("read byte outside a read transfer");

    // Release tick drives idle levels
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.done_res) |->
            (res.chip_select_n && !res.serial_out && !res.serial_clock))
        else $error("release tick with wrong pin levels");

endmodule

`default_nettype wire

### hdl/spimi_in_reg.sv
// Input register for the SPI master instruction transfer block.
// Captures one item and holds it until the engine takes it. Uses spimi_pkg.
`default_nettype none

module spimi_in_reg
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire spimi_pkg::item_t in_item,
    output logic                 held_valid,
    output spimi_pkg::item_t     held_item,
    input  wire logic            take
);

    logic             valid_reg;
    logic             valid_next;
    spimi_pkg::item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

### hdl/spimi_engine.sv
// Transfer engine: phase machine, shift registers and the result register.
// One held item is processed per cycle into one result, unless a result waits. Uses spimi_pkg.
`default_nettype none

module spimi_engine
#(
    parameter int ADDR_BITS = spimi_pkg::ADDR_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire spimi_pkg::cfg_t  cfg,
    input  wire logic             item_valid,
    input  wire spimi_pkg::item_t item,
    output logic                  take,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output spimi_pkg::result_t    res
);

    // Address bits that reach the header, never more than the field holds
    localparam logic [spimi_pkg::ADDR_FIELD-1:0] ADDR_MASK =
        spimi_pkg::ADDR_FIELD'(((1 << ADDR_BITS) - 1) & ((1 << spimi_pkg::ADDR_FIELD) - 1));
    localparam logic [3:0] LAST_HDR_BIT = 4'(spimi_pkg::HEADER_BITS - 1);
    localparam logic [3:0] LAST_DATA_BIT = 4'd7;

    spimi_pkg::phase_t phase_reg, phase_next;
    logic        half_bit_reg, half_bit_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] tx_shift_reg, tx_shift_next;
    logic [7:0]  rx_shift_reg, rx_shift_next;
    logic        reading_reg, reading_next;
    logic        dout_reg, dout_next;
    logic        out_valid_reg;
    spimi_pkg::result_t result_reg, result_next;

    logic        start_ok;
    logic [1:0]  len_code;
    logic [7:0]  bytes_dec;

    // Advance when an item is held and the result slot is free or draining
    assign take = item_valid && (!out_valid_reg || res_ready);

    assign start_ok = item.action && cfg.power_on && (item.byte_count != 8'd0)
                      && (item.address <= {3'b000, cfg.max_address});
    assign len_code = (item.byte_count < 8'd4) ? (item.byte_count[1:0] - 2'd1) : 2'd3;
    assign bytes_dec = bytes_left_reg - 8'd1;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            spimi_pkg::PH_IDLE:
            begin
                if (start_ok)
                begin
                    phase_next = spimi_pkg::PH_HEADER;
                end
            end
            spimi_pkg::PH_HEADER:
            begin
                if (half_bit_reg && (bit_index_reg >= LAST_HDR_BIT))
                begin
                    phase_next = spimi_pkg::PH_DATA;
                end
            end
            spimi_pkg::PH_DATA:
            begin
                if (half_bit_reg && (bit_index_reg >= LAST_DATA_BIT) && (bytes_dec == 8'd0))
                begin
                    phase_next = spimi_pkg::PH_HOLD;
                end
            end
            spimi_pkg::PH_HOLD:    phase_next = spimi_pkg::PH_RELEASE;
            spimi_pkg::PH_RELEASE: phase_next = spimi_pkg::PH_IDLE;
            default:               phase_next = spimi_pkg::PH_IDLE;
        endcase
    end

    // Datapath and pin levels
    always_comb
    begin
        half_bit_next   = half_bit_reg;
        bit_index_next  = bit_index_reg;
        bytes_left_next = bytes_left_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        reading_next    = reading_reg;
        dout_next       = dout_reg;

        result_next               = '0;
        result_next.chip_select_n = 1'b1;
        result_next.start_status  = spimi_pkg::ST_NONE;

        case (phase_reg)
            spimi_pkg::PH_IDLE:
            begin
                if (item.action)
                begin
                    if (start_ok)
                    begin
                        result_next.start_status  = spimi_pkg::ST_ACCEPTED;
                        result_next.chip_select_n = 1'b0;
                        tx_shift_next   = {item.is_read, len_code,
                                           item.address[spimi_pkg::ADDR_FIELD-1:0] & ADDR_MASK};
                        reading_next    = item.is_read;
                        bytes_left_next = item.byte_count;
                        bit_index_next  = 4'd0;
                        half_bit_next   = 1'b0;
                        rx_shift_next   = 8'd0;
                    end
                    else
                    begin
                        result_next.start_status = spimi_pkg::ST_REJECTED;
                    end
                end
                dout_next = 1'b0;
            end
            spimi_pkg::PH_HEADER:
            begin
                result_next.chip_select_n = 1'b0;
                if (!half_bit_reg)
                begin
                    dout_next     = tx_shift_reg[15];
                    half_bit_next = 1'b1;
                end
                else
                begin
                    result_next.serial_clock = 1'b1;
                    half_bit_next = 1'b0;
                    tx_shift_next = {tx_shift_reg[14:0], 1'b0};
                    bit_index_next = (bit_index_reg >= LAST_HDR_BIT) ? 4'd0
                                                                     : bit_index_reg + 4'd1;
                end
            end
            spimi_pkg::PH_DATA:
            begin
                result_next.chip_select_n = 1'b0;
                if (!half_bit_reg)
                begin
                    if (reading_reg)
                    begin
                        // Sample on the clock-low tick
                        rx_shift_next = {rx_shift_reg[6:0], item.serial_in};
                        if (bit_index_reg == LAST_DATA_BIT)
                        begin
                            result_next.read_valid = 1'b1;
                            result_next.read_byte  = {rx_shift_reg[6:0], item.serial_in};
                        end
                    end
                    else
                    begin
                        if (bit_index_reg == 4'd0)
                        begin
                            tx_shift_next = {item.write_byte, 8'd0};
                            result_next.byte_loaded = 1'b1;
                            dout_next = item.write_byte[7];
                        end
                        else
                        begin
                            dout_next = tx_shift_reg[15];
                        end
                    end
                    half_bit_next = 1'b1;
                end
                else
                begin
                    result_next.serial_clock = 1'b1;
                    half_bit_next = 1'b0;
                    if (!reading_reg)
                    begin
                        tx_shift_next = {tx_shift_reg[14:0], 1'b0};
                    end
                    if (bit_index_reg >= LAST_DATA_BIT)
                    begin
                        bit_index_next  = 4'd0;
                        bytes_left_next = bytes_dec;
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + 4'd1;
                    end
                end
            end
            spimi_pkg::PH_HOLD:
            begin
                result_next.chip_select_n = 1'b0;
                result_next.serial_clock  = 1'b1;
            end
            default:
            begin
                // Release: select back high, counters cleared
                dout_next = 1'b0;
                result_next.done_res = 1'b1;
                half_bit_next  = 1'b0;
                bit_index_next = 4'd0;
            end
        endcase

        if ((phase_reg != spimi_pkg::PH_IDLE) && item.action)
        begin
            result_next.start_status = spimi_pkg::ST_BUSY;
        end
        result_next.serial_out = dout_next;
    end

    // Transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= spimi_pkg::PH_IDLE;
            half_bit_reg   <= 1'b0;
            bit_index_reg  <= 4'd0;
            bytes_left_reg <= 8'd0;
            tx_shift_reg   <= 16'd0;
            rx_shift_reg   <= 8'd0;
            reading_reg    <= 1'b0;
            dout_reg       <= 1'b0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            half_bit_reg   <= half_bit_next;
            bit_index_reg  <= bit_index_next;
            bytes_left_reg <= bytes_left_next;
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            reading_reg    <= reading_next;
            dout_reg       <= dout_next;
        end
    end

    // Result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = result_reg;

endmodule

`default_nettype wire
